// File: rtl/rgbyuv_pkg.sv
// Shared types, constants and helpers for the RGB to YUV converter.
// No dependencies; used by every module of the block.
package rgbyuv_pkg;

  // Pixel component and result widths
  localparam int PIX_W  = 8;
  // Q12 chroma value of one pixel fits 21 bits, a pair sum 22 bits
  localparam int SUM_W  = 22;
  // Working width for products, quad sums and rounding
  localparam int WORK_W = 24;
  localparam int CFG_DATA_W = 13;

  // Subsampling mode codes (the remaining code behaves as 4:4:4)
  localparam logic [1:0] MODE_444 = 2'd0;
  localparam logic [1:0] MODE_422 = 2'd1;
  localparam logic [1:0] MODE_420 = 2'd2;

  // Configuration register indexes
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  // Reset values of the configuration registers
  localparam logic [1:0]            MODE_RESET  = MODE_444;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET = 13'd640;

  // Q12 BT.601 coefficients
  localparam logic signed [WORK_W-1:0] K_YR = 24'sd1225;
  localparam logic signed [WORK_W-1:0] K_YG = 24'sd2404;
  localparam logic signed [WORK_W-1:0] K_YB = 24'sd467;
  localparam logic signed [WORK_W-1:0] K_UR = -24'sd603;
  localparam logic signed [WORK_W-1:0] K_UG = -24'sd1183;
  localparam logic signed [WORK_W-1:0] K_UB = 24'sd1786;
  localparam logic signed [WORK_W-1:0] K_VR = 24'sd2519;
  localparam logic signed [WORK_W-1:0] K_VG = -24'sd2109;
  localparam logic signed [WORK_W-1:0] K_VB = -24'sd410;

  // Shift amounts for single pixel, pair average and block average
  localparam int SH_PIX  = 12;
  localparam int SH_PAIR = 13;
  localparam int SH_QUAD = 14;

  // Per-pixel control that travels with the pixel down the pipeline
  typedef struct packed {
    logic [1:0] mode;
    logic       col_odd;
    logic       odd_row;
  } pix_ctrl_t;

  // One line store entry: U and V sums of an upper pixel pair
  typedef struct packed {
    logic signed [SUM_W-1:0] u;
    logic signed [SUM_W-1:0] v;
  } chroma_sum_t;

  // Divide by 2^k truncating toward zero, then clamp to -128..127
  function automatic logic signed [PIX_W-1:0] div_sat(input logic signed [WORK_W-1:0] s,
                                                      input int k);
    logic signed [WORK_W-1:0] bias;
    logic signed [WORK_W-1:0] q;
    bias = s[WORK_W-1] ? WORK_W'((1 << k) - 1) : '0;
    q    = (s + bias) >>> k;
    if (q > 24'sd127) begin
      div_sat = 8'sd127;
    end else if (q < -24'sd128) begin
      div_sat = -8'sd128;
    end else begin
      div_sat = q[PIX_W-1:0];
    end
  endfunction

endpackage

// File: rtl/rgbyuv_csc.sv
// Color space conversion stage: 8-bit luma and Q12 chroma of one pixel, registered.
// Depends on rgbyuv_pkg for coefficients and widths.
module rgbyuv_csc
  import rgbyuv_pkg::*;
(
  input  logic                       clk,
  input  logic                       en,
  input  logic [PIX_W-1:0]           red,
  input  logic [PIX_W-1:0]           green,
  input  logic [PIX_W-1:0]           blue,
  output logic [PIX_W-1:0]           luma,
  output logic signed [SUM_W-1:0]    sum_u,
  output logic signed [SUM_W-1:0]    sum_v
);

  logic signed [WORK_W-1:0] r_s;
  logic signed [WORK_W-1:0] g_s;
  logic signed [WORK_W-1:0] b_s;
  logic signed [WORK_W-1:0] y_acc;
  logic signed [WORK_W-1:0] u_acc;
  logic signed [WORK_W-1:0] v_acc;

  // Constant multiplies and sums of the three components
  always_comb begin
    r_s   = $signed(WORK_W'(red));
    g_s   = $signed(WORK_W'(green));
    b_s   = $signed(WORK_W'(blue));
    y_acc = K_YR * r_s + K_YG * g_s + K_YB * b_s;
    u_acc = K_UR * r_s + K_UG * g_s + K_UB * b_s;
    v_acc = K_VR * r_s + K_VG * g_s + K_VB * b_s;
  end

  // Hold results while the pipeline stalls; luma never exceeds 255
  always_ff @(posedge clk) begin
    if (en) begin
      luma  <= y_acc[SH_PIX +: PIX_W];
      sum_u <= u_acc[SUM_W-1:0];
      sum_v <= v_acc[SUM_W-1:0];
    end
  end

endmodule

// File: rtl/rgbyuv_line_mem.sv
// Chroma line store: one write port, one registered read port, write-first
// on a same-address collision. Depends on rgbyuv_pkg for the entry type.
module rgbyuv_line_mem
  import rgbyuv_pkg::*;
#(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output chroma_sum_t       rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  chroma_sum_t       wr_data
);

  chroma_sum_t mem [DEPTH];

  // Write the upper pair sums
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; forward a write to the same entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// File: rtl/rgbyuv_chroma.sv
// Chroma combine stage: pair partial register, pair and block sums,
// averaging and saturation. Depends on rgbyuv_pkg.
module rgbyuv_chroma
  import rgbyuv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  pix_ctrl_t                ctrl,
  input  logic signed [SUM_W-1:0]  sum_u,
  input  logic signed [SUM_W-1:0]  sum_v,
  input  chroma_sum_t              line_data,
  output logic signed [PIX_W-1:0]  chroma_u,
  output logic signed [PIX_W-1:0]  chroma_v,
  output logic                     chroma_valid,
  output logic                     wr_en,
  output chroma_sum_t              wr_data
);

  chroma_sum_t              partial;
  logic signed [SUM_W-1:0]  pair_u;
  logic signed [SUM_W-1:0]  pair_v;
  logic signed [WORK_W-1:0] quad_u;
  logic signed [WORK_W-1:0] quad_v;

  // Load the partial at every even column, in every mode
  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
    end else if (en && !ctrl.col_odd) begin
      partial.u <= sum_u;
      partial.v <= sum_v;
    end
  end

  // Pair and block sums
  always_comb begin
    pair_u = partial.u + sum_u;
    pair_v = partial.v + sum_v;
    quad_u = WORK_W'(pair_u) + WORK_W'(line_data.u);
    quad_v = WORK_W'(pair_v) + WORK_W'(line_data.v);
  end

  // Store the upper pair at odd columns of even rows
  assign wr_en        = en && ctrl.col_odd && !ctrl.odd_row;
  assign wr_data.u    = pair_u;
  assign wr_data.v    = pair_v;

  // Select the chroma result for the mode
  always_comb begin
    chroma_u     = '0;
    chroma_v     = '0;
    chroma_valid = 1'b0;
    case (ctrl.mode)
      MODE_422: begin
        if (ctrl.col_odd) begin
          chroma_u     = div_sat(WORK_W'(pair_u), SH_PAIR);
          chroma_v     = div_sat(WORK_W'(pair_v), SH_PAIR);
          chroma_valid = 1'b1;
        end
      end
      MODE_420: begin
        if (ctrl.col_odd && ctrl.odd_row) begin
          chroma_u     = div_sat(quad_u, SH_QUAD);
          chroma_v     = div_sat(quad_v, SH_QUAD);
          chroma_valid = 1'b1;
        end
      end
      default: begin
        chroma_u     = div_sat(WORK_W'(sum_u), SH_PIX);
        chroma_v     = div_sat(WORK_W'(sum_v), SH_PIX);
        chroma_valid = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/rgb_to_yuv_subsampled_unit.sv
// RGB to YUV (BT.601, Q12) converter with 4:4:4, 4:2:2 and 4:2:0 chroma.
// Results pass the first stage registers and then the output register.
// Throughput: one pixel per cycle unless the output stalls; the line store has
// one read and one write port (write-first), read at accept, written from stage 1.
// Reset clears counters, pair partial and registers (mode 4:4:4, width 640);
// the line store is not cleared and needs no clearing pass.
module rgb_to_yuv_subsampled_unit
  import rgbyuv_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  // Pixel input
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [23:0]            s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic                   s_tuser,   // frame_start
  // Result output
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [23:0]            m_tdata,   // luma[7:0], chroma_u[15:8], chroma_v[23:16]
  output logic                   m_tuser,   // chroma_valid
  // Configuration write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int HALF = MAX_WIDTH / 2;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int SW   = $clog2(HALF);
  localparam int CMPW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;

  logic [1:0]            subsample_mode;
  logic [CFG_DATA_W-1:0] image_width;
  logic [CW-1:0]         column_count;
  logic                  odd_row;

  logic                  advance;
  logic                  accept;
  logic [CMPW-1:0]       width_eff;
  logic [CW-1:0]         col_now;
  logic                  odd_now;
  logic [CMPW-1:0]       col_inc;
  logic [CW-1:0]         col_half;
  logic [SW-1:0]         rd_slot;

  logic                  s1_valid;
  pix_ctrl_t             s1_ctrl;
  logic [SW-1:0]         s1_slot;
  logic [PIX_W-1:0]      s1_luma;
  logic signed [SUM_W-1:0] s1_su;
  logic signed [SUM_W-1:0] s1_sv;
  chroma_sum_t           line_rd;

  logic                  c_en;
  logic signed [PIX_W-1:0] c_u;
  logic signed [PIX_W-1:0] c_v;
  logic                  c_valid;
  logic                  wr_en;
  chroma_sum_t           wr_data;

  logic [PIX_W-1:0]      out_luma;
  logic [PIX_W-1:0]      out_u;
  logic [PIX_W-1:0]      out_v;
  logic                  out_chroma_valid;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      subsample_mode <= MODE_RESET;
      image_width    <= WIDTH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:  subsample_mode <= cfg_data[1:0];
        REG_WIDTH: image_width    <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Whole pipeline moves when the output register is free or being taken
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && advance;

  // Clamp the row width to 2..MAX_WIDTH
  always_comb begin
    width_eff = CMPW'(image_width);
    if (width_eff < CMPW'(2)) begin
      width_eff = CMPW'(2);
    end else if (width_eff > CMPW'(MAX_WIDTH)) begin
      width_eff = CMPW'(MAX_WIDTH);
    end
  end

  // Position of the incoming pixel and its line store slot
  always_comb begin
    col_now  = s_tuser ? '0 : column_count;
    odd_now  = s_tuser ? 1'b0 : odd_row;
    col_inc  = CMPW'(col_now) + CMPW'(1);
    col_half = col_now >> 1;
    if (col_half >= CW'(HALF)) begin
      rd_slot = SW'(col_half - CW'(HALF));
    end else begin
      rd_slot = SW'(col_half);
    end
  end

  // Advance column and row parity on each accepted pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      odd_row      <= 1'b0;
    end else if (accept) begin
      if (col_inc >= width_eff) begin
        column_count <= '0;
        odd_row      <= !odd_now;
      end else begin
        column_count <= CW'(col_inc);
        odd_row      <= odd_now;
      end
    end
  end

  // First stage: control and slot
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ctrl.mode    <= subsample_mode;
      s1_ctrl.col_odd <= col_now[0];
      s1_ctrl.odd_row <= odd_now;
      s1_slot         <= rd_slot;
    end
  end

  rgbyuv_csc u_csc (
    .clk   (clk),
    .en    (advance),
    .red   (s_tdata[7:0]),
    .green (s_tdata[15:8]),
    .blue  (s_tdata[23:16]),
    .luma  (s1_luma),
    .sum_u (s1_su),
    .sum_v (s1_sv)
  );

  rgbyuv_line_mem #(
    .DEPTH  (HALF),
    .ADDR_W (SW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (advance),
    .rd_addr (rd_slot),
    .rd_data (line_rd),
    .wr_en   (wr_en),
    .wr_addr (s1_slot),
    .wr_data (wr_data)
  );

  assign c_en = advance && s1_valid;

  rgbyuv_chroma u_chroma (
    .clk          (clk),
    .rst          (rst),
    .en           (c_en),
    .ctrl         (s1_ctrl),
    .sum_u        (s1_su),
    .sum_v        (s1_sv),
    .line_data    (line_rd),
    .chroma_u     (c_u),
    .chroma_v     (c_v),
    .chroma_valid (c_valid),
    .wr_en        (wr_en),
    .wr_data      (wr_data)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_luma         <= s1_luma;
      out_u            <= c_u;
      out_v            <= c_v;
      out_chroma_valid <= c_valid;
    end
  end

  assign m_tdata = {out_v, out_u, out_luma};
  assign m_tuser = out_chroma_valid;

endmodule
